// ----- rtl/lrip_pkg.sv -----
// Shared types, constants and the arctangent table of the lidar range image projection.
package lrip_pkg;

    // Field widths of the point, result and configuration beats.
    localparam int POS_W      = 18;
    localparam int RING_W     = 8;
    localparam int ROW_OUT_W  = 4;
    localparam int COL_OUT_W  = 11;
    localparam int IDX_OUT_W  = 15;
    localparam int RANGE_W    = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_USE_RING  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RANGE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VERT_RES  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HORIZ_RES = 3'd4;

    // Register values after reset.
    localparam logic        RST_USE_RING  = 1'b1;
    localparam logic [17:0] RST_MIN_RANGE = 18'd1000;
    localparam logic [13:0] RST_BOTTOM    = 14'd1510;
    localparam logic [13:0] RST_VERT_RES  = 14'd200;
    localparam logic [11:0] RST_HORIZ_RES = 12'd20;

    // CORDIC datapath: vector components and angle in 1/25600 of a degree.
    localparam int CORDIC_STEPS = 20;
    localparam int CW = 40;
    localparam int AW = 26;

    localparam logic signed [AW-1:0] ANG_180 = 26'sd4608000;
    localparam logic signed [AW-1:0] ANG_90  = 26'sd2304000;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [AW-1:0] ang;
    } cordic_t;

    // Rounded atan(2^-step) in angle units.
    function automatic logic signed [AW-1:0] atan_step(input int step);
        logic signed [AW-1:0] t;
        unique case (step)
            0:       t = 26'sd1152000;
            1:       t = 26'sd680065;
            2:       t = 26'sd359328;
            3:       t = 26'sd182400;
            4:       t = 26'sd91554;
            5:       t = 26'sd45822;
            6:       t = 26'sd22916;
            7:       t = 26'sd11459;
            8:       t = 26'sd5730;
            9:       t = 26'sd2865;
            10:      t = 26'sd1432;
            11:      t = 26'sd716;
            12:      t = 26'sd358;
            13:      t = 26'sd179;
            14:      t = 26'sd90;
            15:      t = 26'sd45;
            16:      t = 26'sd22;
            17:      t = 26'sd11;
            18:      t = 26'sd6;
            19:      t = 26'sd3;
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage

// ----- rtl/lrip_if.sv -----
// Handshake interfaces for the point, result and configuration channels.
interface lrip_point_if;
    logic                                valid;
    logic                                ready;
    logic signed [lrip_pkg::POS_W-1:0]   pos_x;
    logic signed [lrip_pkg::POS_W-1:0]   pos_y;
    logic signed [lrip_pkg::POS_W-1:0]   pos_z;
    logic        [lrip_pkg::RING_W-1:0]  ring;

    modport source (output valid, output pos_x, output pos_y, output pos_z, output ring,
                    input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z, input ring,
                    output ready);
endinterface

interface lrip_result_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  kept;
    logic [lrip_pkg::ROW_OUT_W-1:0]        row;
    logic [lrip_pkg::COL_OUT_W-1:0]        column;
    logic [lrip_pkg::IDX_OUT_W-1:0]        cell_index;
    logic [lrip_pkg::RANGE_W-1:0]          range_mm;

    modport source (output valid, output kept, output row, output column, output cell_index,
                    output range_mm, input ready);
    modport sink   (input valid, input kept, input row, input column, input cell_index,
                    input range_mm, output ready);
endinterface

interface lrip_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [lrip_pkg::CFG_IDX_W-1:0]     index;
    logic [lrip_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/lrip_sqrt_cell.sv -----
// One digit cell of the pipelined integer square root: decides a single root bit.
module lrip_sqrt_cell #(
    parameter int VW  = 36,
    parameter int RW  = 18,
    parameter int BIT = 0
) (
    input  logic          clk,
    input  logic          en,
    input  logic [VW-1:0] rem_in,
    input  logic [RW-1:0] root_in,
    output logic [VW-1:0] rem_out,
    output logic [RW-1:0] root_out
);

    logic [VW:0]   trial;
    logic [VW:0]   rem_ext;
    logic [VW-1:0] rem_next;
    logic [RW-1:0] root_next;
    logic [VW-1:0] rem_reg;
    logic [RW-1:0] root_reg;

    // Setting this bit adds (root << (BIT+1)) + 4^BIT to the square.
    always_comb
    begin
        trial   = ((VW+1)'(root_in) << (BIT + 1)) + ((VW+1)'(1) << (2 * BIT));
        rem_ext = {1'b0, rem_in};
        if (rem_ext >= trial)
        begin
            rem_next  = VW'(rem_ext - trial);
            root_next = root_in | (RW'(1) << BIT);
        end
        else
        begin
            rem_next  = rem_in;
            root_next = root_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

// ----- rtl/lrip_cordic_cell.sv -----
// One vectoring CORDIC micro-rotation with its stage register.
module lrip_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic              clk,
    input  logic              en,
    input  lrip_pkg::cordic_t d,
    output lrip_pkg::cordic_t q
);

    logic signed [lrip_pkg::CW-1:0] dx;
    logic signed [lrip_pkg::CW-1:0] dy;
    logic signed [lrip_pkg::AW-1:0] t;
    lrip_pkg::cordic_t              q_next;
    lrip_pkg::cordic_t              q_reg;

    // Rotate towards the x axis; the shifts floor on the old components.
    always_comb
    begin
        dx = d.y >>> STEP;
        dy = d.x >>> STEP;
        t  = lrip_pkg::atan_step(STEP);
        if (!d.y[lrip_pkg::CW-1])
        begin
            q_next.x   = d.x + dx;
            q_next.y   = d.y - dy;
            q_next.ang = d.ang + t;
        end
        else
        begin
            q_next.x   = d.x - dx;
            q_next.y   = d.y + dy;
            q_next.ang = d.ang - t;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

// ----- rtl/lrip_div_cell.sv -----
// One restoring division cell: decides a single quotient bit.
module lrip_div_cell #(
    parameter int RW  = 25,
    parameter int DW  = 22,
    parameter int QW  = 16,
    parameter int BIT = 0
) (
    input  logic          clk,
    input  logic          en,
    input  logic [DW-1:0] den,
    input  logic [RW-1:0] rem_in,
    input  logic [QW-1:0] quot_in,
    output logic [RW-1:0] rem_out,
    output logic [QW-1:0] quot_out
);

    localparam int EW = DW + QW;

    logic [EW-1:0] trial;
    logic [EW-1:0] rem_ext;
    logic [RW-1:0] rem_next;
    logic [QW-1:0] quot_next;
    logic [RW-1:0] rem_reg;
    logic [QW-1:0] quot_reg;

    // Subtract the shifted divisor when it fits.
    always_comb
    begin
        trial   = EW'(den) << BIT;
        rem_ext = EW'(rem_in);
        if (rem_ext >= trial)
        begin
            rem_next  = RW'(rem_ext - trial);
            quot_next = quot_in | (QW'(1) << BIT);
        end
        else
        begin
            rem_next  = rem_in;
            quot_next = quot_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign rem_out  = rem_reg;
    assign quot_out = quot_reg;

endmodule

// ----- rtl/lidar_range_image_projection.sv -----
// A result beat comes out of a chain of registers in this order: the squares, the sums,
// 26 square root cells, 20 CORDIC cells, the dividend register, 16 divider cells, the
// bounds register and the output register. The chain takes one point per cycle unless held.
// The whole chain holds while a finished result waits to be taken.
// Reset clears the stage valid flags and the output valid flag and loads the
// register defaults and the squared minimum range; there is no clearing pass.
module lidar_range_image_projection #(
    parameter int NUM_ROWS    = 16,
    parameter int NUM_COLUMNS = 1800
) (
    input  logic          clk,
    input  logic          rst_n,
    lrip_point_if.sink    point,
    lrip_result_if.source result,
    lrip_cfg_if.sink      cfg
);

    localparam int H_RW = 26;
    localparam int H_VW = 2 * H_RW;
    localparam int R_RW = 18;
    localparam int R_VW = 2 * R_RW;
    localparam int D_RW = 25;
    localparam int D_DW = 22;
    localparam int Q_W  = 16;

    localparam int S_SUM     = 1;
    localparam int S_CORD_IN = S_SUM + H_RW;
    localparam int S_RNG_IN  = S_CORD_IN - R_RW;
    localparam int S_PREP    = S_CORD_IN + lrip_pkg::CORDIC_STEPS + 1;
    localparam int S_FIN     = S_PREP + Q_W + 1;
    localparam int NST       = S_FIN + 1;

    localparam int ROW_W = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int COL_W = $clog2(NUM_COLUMNS);
    localparam int IDX_W = ROW_W + COL_W + 1;

    localparam logic [Q_W-1:0]    ROWS_Q = 16'(NUM_ROWS);
    localparam logic signed [17:0] HALF_S = 18'(NUM_COLUMNS / 2);
    localparam logic signed [17:0] NCOL_S = 18'(NUM_COLUMNS);

    typedef struct packed {
        logic signed [17:0] x;
        logic signed [17:0] y;
        logic signed [17:0] z;
        logic [7:0]         ring;
        logic               rok;
        logic [35:0]        ssq;
    } ctxa_t;

    typedef struct packed {
        logic [7:0]  ring;
        logic        rok;
        logic [17:0] rng;
        logic        neg;
        logic        cneg;
    } ctxb_t;

    // Configuration registers.
    logic        use_ring_reg;
    logic [17:0] min_range_reg;
    logic [13:0] bottom_reg;
    logic [13:0] vres_reg;
    logic [11:0] hres_reg;
    logic [35:0] minsq_reg;

    // Pipeline control and stage data.
    logic               en;
    logic [NST-1:0]     vld_reg;
    logic [35:0]        xx_reg;
    logic [35:0]        yy_reg;
    logic [35:0]        zz_reg;
    ctxa_t              c0_reg;
    ctxa_t              c1_next;
    logic [35:0]        hsq_reg;
    logic [35:0]        ssq_next;
    ctxa_t              ctxa_reg [S_SUM:S_CORD_IN];
    ctxb_t              ctxb_reg [S_CORD_IN+1:S_FIN];
    ctxb_t              prep_next;

    logic [H_VW-1:0]    hrem  [0:H_RW];
    logic [H_RW-1:0]    hroot [0:H_RW];
    logic [R_VW-1:0]    rrem  [0:R_RW];
    logic [R_RW-1:0]    rroot [0:R_RW];

    lrip_pkg::cordic_t  est [0:lrip_pkg::CORDIC_STEPS];
    lrip_pkg::cordic_t  ast [0:lrip_pkg::CORDIC_STEPS];
    logic signed [lrip_pkg::CW-1:0] ax;
    logic signed [lrip_pkg::CW-1:0] ay;

    logic signed [26:0] row_num;
    logic signed [26:0] col_d;
    logic signed [26:0] col_m;
    logic signed [26:0] col_num;
    logic [D_RW-1:0]    prow_reg;
    logic [D_RW-1:0]    pcol_reg;
    logic [D_DW-1:0]    den_row;
    logic [D_DW-1:0]    den_col;

    logic [D_RW-1:0]    drow_rem [0:Q_W];
    logic [Q_W-1:0]     drow_q   [0:Q_W];
    logic [D_RW-1:0]    dcol_rem [0:Q_W];
    logic [Q_W-1:0]     dcol_q   [0:Q_W];

    logic [Q_W-1:0]     row_v;
    logic               row_ok;
    logic signed [17:0] col_a;
    logic signed [17:0] col_b;
    logic               col_ok;
    logic               fin_ok_next;
    logic               fin_ok_reg;
    logic [ROW_W-1:0]   fin_row_reg;
    logic [COL_W-1:0]   fin_col_reg;
    logic [17:0]        fin_rng_reg;

    logic [IDX_W-1:0]   idx_sum;
    logic [31:0]        idx32;
    logic [15:0]        row16;
    logic [15:0]        col16;
    logic               out_vld_reg;
    logic               out_kept_reg;
    logic [3:0]         out_row_reg;
    logic [10:0]        out_col_reg;
    logic [14:0]        out_idx_reg;
    logic [17:0]        out_rng_reg;

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_ring_reg  <= lrip_pkg::RST_USE_RING;
            min_range_reg <= lrip_pkg::RST_MIN_RANGE;
            bottom_reg    <= lrip_pkg::RST_BOTTOM;
            vres_reg      <= lrip_pkg::RST_VERT_RES;
            hres_reg      <= lrip_pkg::RST_HORIZ_RES;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                lrip_pkg::CFG_USE_RING:  use_ring_reg  <= cfg.data[0];
                lrip_pkg::CFG_MIN_RANGE: min_range_reg <= cfg.data[17:0];
                lrip_pkg::CFG_BOTTOM:    bottom_reg    <= cfg.data[13:0];
                lrip_pkg::CFG_VERT_RES:  vres_reg      <= cfg.data[13:0];
                lrip_pkg::CFG_HORIZ_RES: hres_reg      <= cfg.data[11:0];
                default:                 ;
            endcase
        end
    end

    // Squared minimum range, refreshed every cycle from the register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            minsq_reg <= 36'd1000000;
        end
        else
        begin
            minsq_reg <= min_range_reg * min_range_reg;
        end
    end

    // The chain moves whenever the output register is free or being emptied.
    assign en          = !out_vld_reg || result.ready;
    assign point.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], point.valid};
        end
    end

    // Squares of the coordinates.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xx_reg      <= point.pos_x * point.pos_x;
            yy_reg      <= point.pos_y * point.pos_y;
            zz_reg      <= point.pos_z * point.pos_z;
            c0_reg.x    <= point.pos_x;
            c0_reg.y    <= point.pos_y;
            c0_reg.z    <= point.pos_z;
            c0_reg.ring <= point.ring;
            c0_reg.rok  <= 1'b0;
            c0_reg.ssq  <= '0;
        end
    end

    // Horizontal and full sums of squares, and the exact minimum range test.
    assign ssq_next = xx_reg + yy_reg + zz_reg;

    always_comb
    begin
        c1_next     = c0_reg;
        c1_next.ssq = ssq_next;
        c1_next.rok = (ssq_next >= minsq_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hsq_reg         <= xx_reg + yy_reg;
            ctxa_reg[S_SUM] <= c1_next;
            for (int i = S_SUM + 1; i <= S_CORD_IN; i++)
            begin
                ctxa_reg[i] <= ctxa_reg[i-1];
            end
        end
    end

    // Square root of the horizontal distance in 1/256 mm.
    assign hrem[0]  = {hsq_reg, 16'd0};
    assign hroot[0] = '0;

    for (genvar k = 0; k < H_RW; k++)
    begin : g_hsqrt
        lrip_sqrt_cell #(.VW(H_VW), .RW(H_RW), .BIT(H_RW - 1 - k)) u_cell (
            .clk      (clk),
            .en       (en),
            .rem_in   (hrem[k]),
            .root_in  (hroot[k]),
            .rem_out  (hrem[k+1]),
            .root_out (hroot[k+1])
        );
    end

    // Square root of the full sum, timed to finish alongside the horizontal one.
    assign rrem[0]  = ctxa_reg[S_RNG_IN].ssq;
    assign rroot[0] = '0;

    for (genvar j = 0; j < R_RW; j++)
    begin : g_rsqrt
        lrip_sqrt_cell #(.VW(R_VW), .RW(R_RW), .BIT(R_RW - 1 - j)) u_cell (
            .clk      (clk),
            .en       (en),
            .rem_in   (rrem[j]),
            .root_in  (rroot[j]),
            .rem_out  (rrem[j+1]),
            .root_out (rroot[j+1])
        );
    end

    // CORDIC start vectors: elevation from (h, z), azimuth from (y, x).
    always_comb
    begin
        est[0].x   = lrip_pkg::CW'($signed({1'b0, hroot[H_RW], 8'd0}));
        est[0].y   = lrip_pkg::CW'(ctxa_reg[S_CORD_IN].z) <<< 16;
        est[0].ang = '0;
        ax = lrip_pkg::CW'(ctxa_reg[S_CORD_IN].y) <<< 12;
        ay = lrip_pkg::CW'(ctxa_reg[S_CORD_IN].x) <<< 12;
        if (ax[lrip_pkg::CW-1])
        begin
            ast[0].x   = -ax;
            ast[0].y   = -ay;
            ast[0].ang = ay[lrip_pkg::CW-1] ? -lrip_pkg::ANG_180 : lrip_pkg::ANG_180;
        end
        else
        begin
            ast[0].x   = ax;
            ast[0].y   = ay;
            ast[0].ang = '0;
        end
    end

    for (genvar c = 0; c < lrip_pkg::CORDIC_STEPS; c++)
    begin : g_cordic
        lrip_cordic_cell #(.STEP(c)) u_elev (
            .clk (clk),
            .en  (en),
            .d   (est[c]),
            .q   (est[c+1])
        );
        lrip_cordic_cell #(.STEP(c)) u_azim (
            .clk (clk),
            .en  (en),
            .d   (ast[c]),
            .q   (ast[c+1])
        );
    end

    // Dividends: elevation plus bottom angle, and the doubled rounding form of the azimuth.
    // The signs of both travel on with the context into the divider stages.
    always_comb
    begin
        row_num = 27'(est[lrip_pkg::CORDIC_STEPS].ang) + $signed(27'({bottom_reg, 8'd0}));
        col_d   = 27'(ast[lrip_pkg::CORDIC_STEPS].ang) - 27'(lrip_pkg::ANG_90);
        col_m   = col_d[26] ? -col_d : col_d;
        col_num = (col_m <<< 1) + $signed(27'({hres_reg, 8'd0}));
        prep_next      = ctxb_reg[S_PREP-1];
        prep_next.neg  = row_num[26];
        prep_next.cneg = col_d[26];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prow_reg <= row_num[D_RW-1:0];
            pcol_reg <= col_num[D_RW-1:0];
            ctxb_reg[S_CORD_IN+1].ring <= ctxa_reg[S_CORD_IN].ring;
            ctxb_reg[S_CORD_IN+1].rok  <= ctxa_reg[S_CORD_IN].rok;
            ctxb_reg[S_CORD_IN+1].rng  <= rroot[R_RW];
            ctxb_reg[S_CORD_IN+1].neg  <= 1'b0;
            ctxb_reg[S_CORD_IN+1].cneg <= 1'b0;
            for (int i = S_CORD_IN + 2; i <= S_FIN; i++)
            begin
                if (i == S_PREP)
                begin
                    ctxb_reg[i] <= prep_next;
                end
                else
                begin
                    ctxb_reg[i] <= ctxb_reg[i-1];
                end
            end
        end
    end

    // Row and column quotients, one bit per cell.
    assign den_row     = {vres_reg, 8'd0};
    assign den_col     = D_DW'({hres_reg, 9'd0});
    assign drow_rem[0] = prow_reg;
    assign drow_q[0]   = '0;
    assign dcol_rem[0] = pcol_reg;
    assign dcol_q[0]   = '0;

    for (genvar d = 0; d < Q_W; d++)
    begin : g_div
        lrip_div_cell #(.RW(D_RW), .DW(D_DW), .QW(Q_W), .BIT(Q_W - 1 - d)) u_row (
            .clk      (clk),
            .en       (en),
            .den      (den_row),
            .rem_in   (drow_rem[d]),
            .quot_in  (drow_q[d]),
            .rem_out  (drow_rem[d+1]),
            .quot_out (drow_q[d+1])
        );
        lrip_div_cell #(.RW(D_RW), .DW(D_DW), .QW(Q_W), .BIT(Q_W - 1 - d)) u_col (
            .clk      (clk),
            .en       (en),
            .den      (den_col),
            .rem_in   (dcol_rem[d]),
            .quot_in  (dcol_q[d]),
            .rem_out  (dcol_rem[d+1]),
            .quot_out (dcol_q[d+1])
        );
    end

    // Bounds checks, column wrap and the keep decision.
    // A negative azimuth offset gives a negative quotient, which moves the column up.
    always_comb
    begin
        row_v  = use_ring_reg ? {8'd0, ctxb_reg[S_FIN-1].ring} : drow_q[Q_W];
        row_ok = (row_v < ROWS_Q) &&
                 (use_ring_reg || ((vres_reg != '0) && !ctxb_reg[S_FIN-1].neg));
        col_a  = ctxb_reg[S_FIN-1].cneg ? (HALF_S + $signed({2'b00, dcol_q[Q_W]}))
                                        : (HALF_S - $signed({2'b00, dcol_q[Q_W]}));
        col_b  = (col_a >= NCOL_S) ? (col_a - NCOL_S) : col_a;
        col_ok = (hres_reg != '0) && !col_b[17] && (col_b < NCOL_S);
        fin_ok_next = row_ok && col_ok && ctxb_reg[S_FIN-1].rok;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fin_ok_reg  <= fin_ok_next;
            fin_row_reg <= fin_ok_next ? row_v[ROW_W-1:0] : '0;
            fin_col_reg <= fin_ok_next ? col_b[COL_W-1:0] : '0;
            fin_rng_reg <= ctxb_reg[S_FIN-1].rng;
        end
    end

    // Output register holding the result beat.
    assign idx_sum = IDX_W'(fin_col_reg) + IDX_W'(fin_row_reg) * IDX_W'(NUM_COLUMNS);
    assign idx32   = 32'(idx_sum);
    assign row16   = 16'(fin_row_reg);
    assign col16   = 16'(fin_col_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= vld_reg[NST-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_kept_reg <= fin_ok_reg;
            out_row_reg  <= row16[3:0];
            out_col_reg  <= col16[10:0];
            out_idx_reg  <= idx32[14:0];
            out_rng_reg  <= fin_rng_reg;
        end
    end

    assign result.valid      = out_vld_reg;
    assign result.kept       = out_kept_reg;
    assign result.row        = out_row_reg;
    assign result.column     = out_col_reg;
    assign result.cell_index = out_idx_reg;
    assign result.range_mm   = out_rng_reg;

    // An accepted point enters the first stage.
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (point.valid && point.ready) |=> vld_reg[0])
        else $error("accepted point did not enter the first stage");

    // A held chain keeps every stage flag.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("stage flags moved while the chain was held");

    // A new result beat comes from the last stage.
    a_out_from_chain: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(vld_reg[NST-1]))
        else $error("result beat appeared without a point in the last stage");

    // A dropped point carries zero position fields.
    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !out_kept_reg) |->
        (out_row_reg == '0 && out_col_reg == '0 && out_idx_reg == '0))
        else $error("dropped point has non-zero position fields");

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for the lidar range image projection: stimulus, result prediction and checks.
`timescale 1ns / 100ps

typedef logic signed [lrip_pkg::POS_W-1:0]      pos_t;
typedef logic        [lrip_pkg::RING_W-1:0]     ring_t;
typedef logic        [lrip_pkg::CFG_IDX_W-1:0]  cfg_idx_t;
typedef logic        [lrip_pkg::CFG_DATA_W-1:0] cfg_data_t;
typedef logic        [lrip_pkg::IDX_OUT_W-1:0]  idx_t;

typedef struct packed {
    logic                           kept;
    logic [lrip_pkg::ROW_OUT_W-1:0] row;
    logic [lrip_pkg::COL_OUT_W-1:0] column;
    logic [lrip_pkg::IDX_OUT_W-1:0] cell_index;
    logic [lrip_pkg::RANGE_W-1:0]   range_mm;
} pixel_t;

// Predicts the image cell and range of each accepted point and holds them until they come out.
class pixel_scoreboard;
    localparam int ROWS = 16;
    localparam int COLS = 1800;

    pixel_t           pending[$];
    int               errors;
    int               points;
    int               kept_seen;
    bit               use_ring;
    longint unsigned  min_range;
    longint           bottom;
    longint           vres;
    longint           hres;
    longint           atan_lut[20];

    function new();
        atan_lut = '{1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
                     5730, 2865, 1432, 716, 358, 179, 90, 45, 22, 11, 6, 3};
        use_ring  = 1'b1;
        min_range = 1000;
        bottom    = 1510;
        vres      = 200;
        hres      = 20;
    endfunction

    // Mirror a register write that the block has accepted.
    function void set_reg(cfg_idx_t idx, cfg_data_t data);
        unique case (idx)
            lrip_pkg::CFG_USE_RING:  use_ring  = data[0];
            lrip_pkg::CFG_MIN_RANGE: min_range = data;
            lrip_pkg::CFG_BOTTOM:    bottom    = data[13:0];
            lrip_pkg::CFG_VERT_RES:  vres      = data[13:0];
            lrip_pkg::CFG_HORIZ_RES: hres      = data[11:0];
            default: ;
        endcase
    endfunction

    function longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Vectoring CORDIC: angle of the vector (b, a) in 1/25600 degree.
    function longint vector_angle(longint a, longint b);
        longint vx;
        longint vy;
        longint ang;
        longint sx;
        longint sy;
        vx  = b;
        vy  = a;
        ang = 0;
        if (vx < 0)
        begin
            ang = (vy >= 0) ? 64'sd4608000 : -64'sd4608000;
            vx  = -vx;
            vy  = -vy;
        end
        for (int i = 0; i < 20; i++)
        begin
            sx = vy >>> i;
            sy = vx >>> i;
            if (vy >= 0)
            begin
                vx  = vx + sx;
                vy  = vy - sy;
                ang = ang + atan_lut[i];
            end
            else
            begin
                vx  = vx - sx;
                vy  = vy + sy;
                ang = ang - atan_lut[i];
            end
        end
        return ang;
    endfunction

    // Work out the expected pixel for a point and queue it.
    function void note_point(pos_t px, pos_t py, pos_t pz, ring_t ring);
        longint          x;
        longint          y;
        longint          z;
        longint unsigned hsq;
        longint unsigned ssq;
        longint unsigned rng;
        longint          row;
        longint          col;
        longint          hd;
        longint          num;
        longint          d;
        longint          m;
        longint          q;
        bit              ok;
        pixel_t          p;
        x   = px;
        y   = py;
        z   = pz;
        hsq = x * x + y * y;
        ssq = hsq + z * z;
        rng = floor_sqrt(ssq);
        if (rng > 262143)
            rng = 262143;
        ok  = 1'b1;
        row = 0;
        col = 0;
        if (use_ring)
            row = ring;
        else if (vres == 0)
            ok = 1'b0;
        else
        begin
            hd  = floor_sqrt(hsq << 16);
            num = vector_angle(z * 65536, hd * 256) + bottom * 256;
            if (num < 0)
                ok = 1'b0;
            else
                row = num / (vres * 256);
        end
        if (ok && row >= ROWS)
            ok = 1'b0;
        if (ok)
        begin
            if (hres == 0)
                ok = 1'b0;
            else
            begin
                d   = vector_angle(x * 4096, y * 4096) - 64'sd2304000;
                m   = (d < 0) ? -d : d;
                q   = (2 * m + hres * 256) / (2 * hres * 256);
                if (d < 0)
                    q = -q;
                col = COLS / 2 - q;
                if (col >= COLS)
                    col = col - COLS;
                if (col < 0 || col >= COLS)
                    ok = 1'b0;
            end
        end
        if (ok && ssq < min_range * min_range)
            ok = 1'b0;
        if (!ok)
        begin
            row = 0;
            col = 0;
        end
        p.kept       = ok;
        p.row        = row[lrip_pkg::ROW_OUT_W-1:0];
        p.column     = col[lrip_pkg::COL_OUT_W-1:0];
        p.cell_index = idx_t'(col + row * COLS);
        p.range_mm   = rng[lrip_pkg::RANGE_W-1:0];
        pending.insert(pending.size(), p);
        points++;
    endfunction

    task report(string what, longint got, longint want);
        errors++;
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    endtask

    // Compare one result beat with the oldest prediction.
    task check_pixel(pixel_t got);
        pixel_t want;
        if (pending.size() == 0)
        begin
            report("unexpected result beat, queue depth", 0, 1);
            return;
        end
        want = pending.pop_front();
        if (got.kept)
            kept_seen++;
        if (got.kept != want.kept)
            report("kept", got.kept, want.kept);
        if (got.row != want.row)
            report("row", got.row, want.row);
        if (got.column != want.column)
            report("column", got.column, want.column);
        if (got.cell_index != want.cell_index)
            report("cell_index", got.cell_index, want.cell_index);
        if (got.range_mm != want.range_mm)
            report("range_mm", got.range_mm, want.range_mm);
    endtask
endclass

module tb_top;
    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;
    // An index past the end of the register list.
    localparam cfg_idx_t CFG_SPARE_IDX = 3'd7;

    logic clk;
    logic rst_n;
    int   idle_cycles;
    bit   hold_off;

    pixel_scoreboard sb;

    lrip_point_if  point ();
    lrip_result_if result ();
    lrip_cfg_if    cfg ();

    lidar_range_image_projection #(
        .NUM_ROWS    (16),
        .NUM_COLUMNS (1800)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .point  (point.sink),
        .result (result.source),
        .cfg    (cfg.sink)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #2 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side: random back-pressure plus one long hold-off on request.
    initial
    begin
        int g;
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                result.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off = 1'b0;
                result.ready <= 1'b1;
            end
            else
            begin
                g = gap_len();
                if (g == 0)
                    result.ready <= 1'b1;
                else
                begin
                    result.ready <= 1'b0;
                    repeat (g - 1) @(posedge clk);
                end
            end
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && result.valid && result.ready)
            sb.check_pixel({result.kept, result.row, result.column, result.cell_index,
                            result.range_mm});
    end

    // Watchdog on cycles with no beat moving on any channel.
    always @(posedge clk)
    begin
        if (!rst_n || (point.valid && point.ready) || (result.valid && result.ready) ||
            (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no beat for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(cfg_idx_t idx, cfg_data_t data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do
            @(posedge clk);
        while (!cfg.ready);
        sb.set_reg(idx, data);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one point; returns at the edge where it is accepted, valid still high.
    task automatic send_point(pos_t px, pos_t py, pos_t pz, ring_t ring);
        point.valid <= 1'b1;
        point.pos_x <= px;
        point.pos_y <= py;
        point.pos_z <= pz;
        point.ring  <= ring;
        do
            @(posedge clk);
        while (!point.ready);
        sb.note_point(px, py, pz, ring);
    endtask

    task automatic pause_point();
        int g;
        g = gap_len();
        if (g > 0)
        begin
            point.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic drain();
        point.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // Extremes, axis directions, ring limits and elevation corner cases.
    task automatic directed_points();
        send_point(0, 0, 0, 0);                         pause_point();
        send_point(18'sh1FFFF, 18'sh1FFFF, 18'sh1FFFF, 8'd255); pause_point();
        send_point(-18'sh20000, -18'sh20000, -18'sh20000, 8'd15); pause_point();
        send_point(-18'sh20000, 0, 0, 8'd16);           pause_point();
        send_point(5000, 0, 0, 8'd0);                   pause_point();
        send_point(0, 5000, 0, 8'd1);                   pause_point();
        send_point(-5000, 0, 0, 8'd2);                  pause_point();
        send_point(0, -5000, 0, 8'd3);                  pause_point();
        send_point(0, -5000, 1, 8'd4);                  pause_point();
        send_point(-1, -5000, 0, 8'd5);                 pause_point();
        send_point(1, -5000, 0, 8'd6);                  pause_point();
        send_point(3000, 3000, -1500, 8'd7);            pause_point();
        send_point(3000, 3000, -9000, 8'd8);            pause_point();
        send_point(3000, 3000, 1000, 8'd9);             pause_point();
        send_point(0, 0, 5000, 8'd10);                  pause_point();
        send_point(0, 0, -5000, 8'd11);                 pause_point();
        send_point(999, 0, 0, 8'd12);                   pause_point();
        send_point(1000, 0, 0, 8'd13);                  pause_point();
        send_point(600, 800, 0, 8'd14);                 pause_point();
        send_point(18'sh1FFFF, -18'sh20000, 0, 8'd128);  pause_point();
    endtask

    task automatic random_points(int count, int hold_at);
        pos_t  px;
        pos_t  py;
        pos_t  pz;
        ring_t ring;
        int    kind;
        for (int n = 0; n < count; n++)
        begin
            if (n == hold_at)
                hold_off = 1'b1;
            kind = $urandom_range(0, 9);
            if (kind < 2)
            begin
                px   = pos_t'($urandom);
                py   = pos_t'($urandom);
                pz   = pos_t'($urandom);
                ring = ring_t'($urandom);
            end
            else if (kind < 3)
            begin
                px   = pos_t'($signed($urandom_range(0, 2400)) - 1200);
                py   = pos_t'($signed($urandom_range(0, 2400)) - 1200);
                pz   = pos_t'($signed($urandom_range(0, 600)) - 300);
                ring = ring_t'($urandom_range(0, 17));
            end
            else
            begin
                px   = pos_t'($signed($urandom_range(0, 40000)) - 20000);
                py   = pos_t'($signed($urandom_range(0, 40000)) - 20000);
                pz   = pos_t'($signed($urandom_range(0, 6000)) - 3000);
                ring = ring_t'($urandom_range(0, 17));
            end
            send_point(px, py, pz, ring);
            pause_point();
        end
    endtask

    // Register settings per phase: use_ring, min range, bottom angle, vertical and horizontal pitch.
    initial
    begin
        int phase_cfg[7][5];
        phase_cfg = '{'{1, 1000, 1510, 200, 20},
                      '{0, 1000, 1510, 200, 20},
                      '{0, 0, 0, 1, 1},
                      '{0, 262143, 9000, 9000, 3600},
                      '{1, 0, 9000, 1, 3600},
                      '{0, 500, 1510, 0, 0},
                      '{0, 300, 2000, 250, 18}};
        sb          = new();
        idle_cycles = 0;
        hold_off    = 1'b0;
        rst_n       = 1'b0;
        point.valid = 1'b0;
        point.pos_x = '0;
        point.pos_y = '0;
        point.pos_z = '0;
        point.ring  = '0;
        cfg.valid   = 1'b0;
        cfg.index   = lrip_pkg::CFG_USE_RING;
        cfg.data    = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < 7; ph++)
        begin
            if (ph > 0)
            begin
                write_reg(lrip_pkg::CFG_USE_RING,  cfg_data_t'(phase_cfg[ph][0]));
                write_reg(lrip_pkg::CFG_MIN_RANGE, cfg_data_t'(phase_cfg[ph][1]));
                write_reg(lrip_pkg::CFG_BOTTOM,    cfg_data_t'(phase_cfg[ph][2]));
                write_reg(lrip_pkg::CFG_VERT_RES,  cfg_data_t'(phase_cfg[ph][3]));
                write_reg(lrip_pkg::CFG_HORIZ_RES, cfg_data_t'(phase_cfg[ph][4]));
                // An index past the register list must leave everything alone.
                write_reg(CFG_SPARE_IDX, 18'h3FFFF);
            end
            if (ph < 2)
                directed_points();
            random_points(180, (ph == 1) ? 40 : -1);
            drain();
        end

        repeat (100) @(posedge clk);
        $display("Covered %0d points over 7 register settings, %0d landed in the image.",
                 sb.points, sb.kept_seen);
        $display("Settings took in ring and elevation rows, zero and extreme pitches and ranges.");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
